>>> rtl/servo_bus_instruction_packet_framer_macros.svh
// Assertion helpers; expect clock and reset in scope.
`ifndef SERVO_BUS_INSTRUCTION_PACKET_FRAMER_MACROS_SVH
`define SERVO_BUS_INSTRUCTION_PACKET_FRAMER_MACROS_SVH

`define SBPF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbpf check failed");

`define SBPF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbpf check failed");

`endif

>>> rtl/sbpf_pkg.sv
`timescale 1ns / 1ps
package sbpf_pkg;

   localparam int MAX_VALUE_BYTES_DEF = 4;
   localparam int IDX_W               = 4;
   localparam int VCNT_W              = 3;

   localparam logic [2:0] MODE_WRITE     = 3'd0;
   localparam logic [2:0] MODE_REG_WRITE = 3'd1;
   localparam logic [2:0] MODE_READ      = 3'd2;
   localparam logic [2:0] MODE_PING      = 3'd3;
   localparam logic [2:0] MODE_ACTION    = 3'd4;

   localparam logic [7:0] INSTR_PING      = 8'h01;
   localparam logic [7:0] INSTR_READ      = 8'h02;
   localparam logic [7:0] INSTR_WRITE     = 8'h03;
   localparam logic [7:0] INSTR_REG_WRITE = 8'h04;
   localparam logic [7:0] INSTR_ACTION    = 8'h05;

   localparam logic [7:0] HDR_SYNC = 8'hFF;
   localparam logic [7:0] HDR_MARK = 8'hFD;
   localparam logic [7:0] HDR_RSVD = 8'h00;

   localparam logic [15:0] CRC_POLY = 16'h8005;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic             load;
      logic             send;
      logic             last;
      logic [IDX_W-1:0] idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic             req_legal;
      logic [IDX_W-1:0] last_idx;
   } dp_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] instr_of(input logic [2:0] mode);
      logic [7:0] r;
      case (mode)
         MODE_WRITE:     r = INSTR_WRITE;
         MODE_REG_WRITE: r = INSTR_REG_WRITE;
         MODE_READ:      r = INSTR_READ;
         MODE_PING:      r = INSTR_PING;
         MODE_ACTION:    r = INSTR_ACTION;
         default:        r = INSTR_PING;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/sbpf_ctrl.sv
`timescale 1ns / 1ps
`include "servo_bus_instruction_packet_framer_macros.svh"
module sbpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sbpf_pkg::dp_status_type status,
   output sbpf_pkg::ctrl_cmd_type  cmd
);
   import sbpf_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && status.req_legal) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (idx_ff == status.last_idx) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load = 1'b0;
      cmd.send = 1'b0;
      cmd.last = 1'b0;
      cmd.idx  = idx_ff;
      busy     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start && status.req_legal;
         end
         ST_SEND: begin
            busy     = 1'b1;
            cmd.send = 1'b1;
            cmd.last = (idx_ff == status.last_idx);
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.send) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   `SBPF_ASSERT_SAME(a_enter_on_accept, $rose(busy), $past(start && status.req_legal))
   `SBPF_ASSERT_NEXT(a_idle_after_last, cmd.send && cmd.last, !busy)
   `SBPF_ASSERT_SAME(a_idx_in_packet, cmd.send, idx_ff <= status.last_idx)

endmodule

>>> rtl/sbpf_datapath.sv
`timescale 1ns / 1ps
module sbpf_datapath #(
   parameter int MAX_VALUE_BYTES = sbpf_pkg::MAX_VALUE_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [2:0]              req_mode,
   input  logic [7:0]              req_target_id,
   input  logic [15:0]             req_reg_address,
   input  logic [31:0]             req_write_value,
   input  logic [7:0]              req_byte_count,
   input  sbpf_pkg::ctrl_cmd_type  cmd,
   output sbpf_pkg::dp_status_type status,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_last_byte
);
   import sbpf_pkg::*;

   localparam logic [7:0] MaxCnt = 8'(MAX_VALUE_BYTES);

   logic [7:0]        id_ff;
   logic [15:0]       addr_ff;
   logic [31:0]       value_ff;
   logic [7:0]        cnt_ff;
   logic [7:0]        instr_ff;
   logic              is_read_ff;
   logic [IDX_W-1:0]  plen_ff, plen_in;
   logic [15:0]       crc_ff, crc_in;
   logic              strobe_ff;
   logic [7:0]        tx_ff;
   logic              last_ff;

   logic [VCNT_W-1:0] vcnt;
   logic [IDX_W-1:0]  pay_len;
   logic [1:0]        vsel;
   logic [7:0]        byte_sel;

   assign status.req_legal = (req_mode <= MODE_ACTION);
   assign status.last_idx  = plen_ff + IDX_W'(6);
   assign pay_len          = plen_ff + IDX_W'(5);

   always_comb begin
      if (req_byte_count == 8'd0) begin
         vcnt = VCNT_W'(1);
      end else if (req_byte_count > MaxCnt) begin
         vcnt = VCNT_W'(MAX_VALUE_BYTES);
      end else begin
         vcnt = req_byte_count[VCNT_W-1:0];
      end
      case (req_mode)
         MODE_WRITE, MODE_REG_WRITE: plen_in = IDX_W'(vcnt) + IDX_W'(5);
         MODE_READ:                  plen_in = IDX_W'(7);
         default:                    plen_in = IDX_W'(3);
      endcase
   end

   // value bytes start at packet offset 10
   assign vsel = 2'(cmd.idx - IDX_W'(10));

   always_comb begin
      case (cmd.idx)
         4'd0, 4'd1: byte_sel = HDR_SYNC;
         4'd2:       byte_sel = HDR_MARK;
         4'd3:       byte_sel = HDR_RSVD;
         4'd4:       byte_sel = id_ff;
         4'd5:       byte_sel = 8'(plen_ff);
         4'd6:       byte_sel = 8'h00;
         4'd7:       byte_sel = instr_ff;
         4'd8:       byte_sel = addr_ff[7:0];
         4'd9:       byte_sel = addr_ff[15:8];
         default: begin
            if (is_read_ff) begin
               byte_sel = (cmd.idx == IDX_W'(10)) ? cnt_ff : 8'h00;
            end else begin
               byte_sel = 8'(value_ff >> {vsel, 3'b000});
            end
         end
      endcase
      if (cmd.idx == pay_len) begin
         byte_sel = crc_ff[7:0];
      end else if (cmd.idx > pay_len) begin
         byte_sel = crc_ff[15:8];
      end
   end

   always_comb begin
      crc_in = crc_ff;
      if (cmd.load) begin
         crc_in = '0;
      end else if (cmd.send && (cmd.idx < pay_len)) begin
         crc_in = crc_byte(crc_ff, byte_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff      <= req_target_id;
         addr_ff    <= req_reg_address;
         value_ff   <= req_write_value;
         cnt_ff     <= req_byte_count;
         instr_ff   <= instr_of(req_mode);
         is_read_ff <= (req_mode == MODE_READ);
         plen_ff    <= plen_in;
      end
      crc_ff <= crc_in;
      if (cmd.send) begin
         tx_ff   <= byte_sel;
         last_ff <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.send;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_tx_byte   = tx_ff;
   assign rsp_last_byte = strobe_ff && last_ff;

endmodule

>>> rtl/servo_bus_instruction_packet_framer.sv
`timescale 1ns / 1ps
// Builds one servo bus instruction packet per accepted item and streams it out one byte per
// cycle on rsp_tx_byte, each byte marked by a one-cycle rsp_strobe, with rsp_last_byte on the
// CRC high byte. The receiver cannot stall, so it must take a byte in every strobed cycle.
// A packet is 12+n bytes for writes (n value bytes, 1..MAX_VALUE_BYTES), 14 for read and 10
// for ping and action; the byte sequencer emits one byte per cycle and the CRC is updated a
// byte per cycle alongside. busy stays high while the bytes of a packet are sent, and the
// next item is taken only once busy has dropped, so a new item never overlaps a packet.
// Items with a mode above 4 are taken and dropped without any output.
module servo_bus_instruction_packet_framer #(
   parameter int MAX_VALUE_BYTES = sbpf_pkg::MAX_VALUE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_target_id,
   input  logic [15:0] req_reg_address,
   input  logic [31:0] req_write_value,
   input  logic [7:0]  req_byte_count,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte
);
   import sbpf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sbpf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   sbpf_datapath #(
      .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_target_id   (req_target_id),
      .req_reg_address (req_reg_address),
      .req_write_value (req_write_value),
      .req_byte_count  (req_byte_count),
      .cmd             (cmd),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

>>> dv/servo_bus_instruction_packet_framer_test.sv
`timescale 1ns / 1ps
module servo_bus_instruction_packet_framer_test;
   import sbpf_pkg::*;

   localparam logic [2:0] MODE_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] MODE_UNKNOWN_HI = 3'd7;
   localparam int VALUE_BYTES_MAX = MAX_VALUE_BYTES_DEF;
   localparam int NUM_RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT = 100000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } tx_beat_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  id;
      logic [15:0] addr;
      logic [31:0] val;
      logic [7:0]  cnt;
      logic [4:0]  len;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_mode = '0;
   logic [7:0]  req_target_id = '0;
   logic [15:0] req_reg_address = '0;
   logic [31:0] req_write_value = '0;
   logic [7:0]  req_byte_count = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_byte;

   tx_beat_type tx_bytes_due[$];
   int          pkt_len_due[$];
   int          bytes_in_pkt = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   // mode, id, address, value, byte count; all rows typed with their packet length
   stim_row_type directed_rows [18] = '{
      '{MODE_PING,       8'h00, 16'h0000, 32'h00000000, 8'h00, 5'd10},
      '{MODE_PING,       8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 5'd10},
      '{MODE_ACTION,     8'hFE, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 5'd10},
      '{MODE_ACTION,     8'h00, 16'h0000, 32'h00000000, 8'h00, 5'd10},
      '{MODE_READ,       8'h01, 16'h0000, 32'h00000000, 8'h00, 5'd14},
      '{MODE_READ,       8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 5'd14},
      '{MODE_WRITE,      8'h01, 16'h0074, 32'hFFFFFFFF, 8'h00, 5'd13},
      '{MODE_WRITE,      8'h02, 16'h0000, 32'hA5A5A5A5, 8'h01, 5'd13},
      '{MODE_WRITE,      8'h03, 16'h8000, 32'h5A5A5A5A, 8'h02, 5'd14},
      '{MODE_WRITE,      8'h04, 16'h7FFF, 32'h00FF00FF, 8'h03, 5'd15},
      '{MODE_WRITE,      8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'h04, 5'd16},
      '{MODE_WRITE,      8'h05, 16'h1234, 32'h89ABCDEF, 8'h05, 5'd16},
      '{MODE_WRITE,      8'h06, 16'h0001, 32'h00000000, 8'hFF, 5'd16},
      '{MODE_REG_WRITE,  8'hFF, 16'hFFFF, 32'h80000001, 8'h00, 5'd13},
      '{MODE_REG_WRITE,  8'h07, 16'h0102, 32'h12345678, 8'h04, 5'd16},
      '{MODE_REG_WRITE,  8'h00, 16'h0000, 32'hFFFFFFFF, 8'hC8, 5'd16},
      '{MODE_UNKNOWN_LO, 8'h11, 16'h2222, 32'h33333333, 8'h04, 5'd0},
      '{MODE_UNKNOWN_HI, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 5'd0}
   };

   servo_bus_instruction_packet_framer dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_target_id   (req_target_id),
      .req_reg_address (req_reg_address),
      .req_write_value (req_write_value),
      .req_byte_count  (req_byte_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // Builds the packet bytes for one request onto the expected queue; returns its length.
   function automatic int frame_packet(input logic [2:0] mode, input logic [7:0] id,
                                       input logic [15:0] addr, input logic [31:0] val,
                                       input logic [7:0] cnt);
      logic [7:0]  pkt [16];
      logic [7:0]  instr;
      logic [15:0] plen;
      logic [15:0] crc;
      int          n;
      int          nval;
      tx_beat_type beat;
      n = 0;
      nval = 0;
      crc = '0;
      case (mode)
         MODE_WRITE:     instr = INSTR_WRITE;
         MODE_REG_WRITE: instr = INSTR_REG_WRITE;
         MODE_READ:      instr = INSTR_READ;
         MODE_PING:      instr = INSTR_PING;
         MODE_ACTION:    instr = INSTR_ACTION;
         default:        return 0;
      endcase
      if (mode == MODE_WRITE || mode == MODE_REG_WRITE) begin
         nval = (cnt == 0) ? 1 : ((cnt > VALUE_BYTES_MAX) ? VALUE_BYTES_MAX : int'(cnt));
         plen = 16'(5 + nval);
      end else if (mode == MODE_READ) begin
         plen = 16'd7;
      end else begin
         plen = 16'd3;
      end
      pkt[0] = HDR_SYNC;
      pkt[1] = HDR_SYNC;
      pkt[2] = HDR_MARK;
      pkt[3] = HDR_RSVD;
      pkt[4] = id;
      pkt[5] = plen[7:0];
      pkt[6] = plen[15:8];
      pkt[7] = instr;
      n = 8;
      if (mode == MODE_WRITE || mode == MODE_REG_WRITE || mode == MODE_READ) begin
         pkt[n++] = addr[7:0];
         pkt[n++] = addr[15:8];
         if (mode == MODE_READ) begin
            pkt[n++] = cnt;
            pkt[n++] = 8'h00;
         end else begin
            for (int i = 0; i < nval; i++) pkt[n++] = val[8*i +: 8];
         end
      end
      for (int i = 0; i < n; i++) begin
         crc = crc ^ {pkt[i], 8'h00};
         for (int k = 0; k < 8; k++)
            crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
      end
      pkt[n++] = crc[7:0];
      pkt[n++] = crc[15:8];
      for (int i = 0; i < n; i++) begin
         beat.tx_byte = pkt[i];
         beat.last = (i == n - 1);
         tx_bytes_due.push_back(beat);
      end
      return n;
   endfunction

   // Called right after a rising edge; offers the item and returns once busy is low again.
   task automatic send_item(input logic [2:0] mode, input logic [7:0] id,
                            input logic [15:0] addr, input logic [31:0] val,
                            input logic [7:0] cnt, input int typed_len, input int gap);
      int len;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_target_id   <= id;
      req_reg_address <= addr;
      req_write_value <= val;
      req_byte_count  <= cnt;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      len = frame_packet(mode, id, addr, val, cnt);
      if (typed_len >= 0) begin
         if (typed_len > 0 || len > 0) pkt_len_due.push_back(typed_len);
      end else if (len > 0) begin
         pkt_len_due.push_back(len);
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (tx_bytes_due.size() != 0) @(posedge clock);
   endtask

   function automatic int draw_gap(input int item_no);
      return ((item_no % 100) < 30) ? 0 : $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin
      tx_beat_type exp_beat;
      int          want_len;
      if (!reset && rsp_strobe === 1'b1) begin
         if (tx_bytes_due.size() == 0) begin
            report_mismatch("byte with none expected", int'(rsp_tx_byte), 0);
         end else begin
            exp_beat = tx_bytes_due.pop_front();
            if (rsp_tx_byte !== exp_beat.tx_byte)
               report_mismatch("tx_byte", int'(rsp_tx_byte), int'(exp_beat.tx_byte));
            if (rsp_last_byte !== exp_beat.last)
               report_mismatch("last_byte", int'(rsp_last_byte), int'(exp_beat.last));
         end
         bytes_in_pkt++;
         if (rsp_last_byte === 1'b1) begin
            if (pkt_len_due.size() == 0) begin
               report_mismatch("packet end with none expected", bytes_in_pkt, 0);
            end else begin
               want_len = pkt_len_due.pop_front();
               if (bytes_in_pkt != want_len)
                  report_mismatch("packet length", bytes_in_pkt, want_len);
            end
            bytes_in_pkt = 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int          sent;
      int          item_no;
      logic [2:0]  mode;
      logic [7:0]  cnt;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      item_no = 0;
      for (int r = 0; r < $size(directed_rows); r++) begin
         send_item(directed_rows[r].mode, directed_rows[r].id, directed_rows[r].addr,
                   directed_rows[r].val, directed_rows[r].cnt, int'(directed_rows[r].len),
                   draw_gap(item_no));
         item_no++;
      end
      hold_until_drained();

      sent = 0;
      while (sent < NUM_RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 4)
            mode = 3'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
         else
            mode = 3'($urandom_range(MODE_WRITE, MODE_ACTION));
         cnt = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
         send_item(mode, 8'($urandom), 16'($urandom), $urandom, cnt, -1, draw_gap(item_no));
         item_no++;
         if (mode <= MODE_ACTION) sent++;
         if (sent % 97 == 50) hold_until_drained();
      end

      start <= 1'b0;
      @(posedge clock);
      while (tx_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tx_bytes_due.size() != 0)
         report_mismatch("bytes never sent", tx_bytes_due.size(), 0);
      if (pkt_len_due.size() != 0)
         report_mismatch("packets never ended", pkt_len_due.size(), 0);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
